FILE: sv/pbsd_pkg.sv
package pbsd_pkg;

  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_ROOT_MIN_X = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ROOT_MAX_X = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ROOT_MIN_Y = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ROOT_MAX_Y = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_ROOT_MIN_Z = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_ROOT_MAX_Z = 3'd5;

  typedef struct packed {
    logic outside;
    logic face_ok;
  } axis_flags_t;

endpackage

FILE: sv/pbsd_query_if.sv
interface pbsd_query_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] box_max_z;
  logic                         inner_only;
  logic                         check_data;
  logic                         node_empty;

  modport source (
    output valid, point_x, point_y, point_z, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, inner_only, check_data, node_empty,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, inner_only, check_data, node_empty,
    output ready
  );
endinterface

FILE: sv/pbsd_result_if.sv
interface pbsd_result_if #(
  parameter int COORD_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [2*COORD_BITS+1:0]       dist_squared;
  logic                          dist_is_max;
  logic signed [COORD_BITS-1:0]  closest_x;
  logic signed [COORD_BITS-1:0]  closest_y;
  logic signed [COORD_BITS-1:0]  closest_z;

  modport source (
    output valid, dist_squared, dist_is_max, closest_x, closest_y, closest_z,
    input  ready
  );

  modport sink (
    input  valid, dist_squared, dist_is_max, closest_x, closest_y, closest_z,
    output ready
  );
endinterface

FILE: sv/pbsd_axis.sv
module pbsd_axis #(
  parameter int COORD_BITS = 24
) (
  input  logic signed [COORD_BITS-1:0] p,
  input  logic signed [COORD_BITS-1:0] lo,
  input  logic signed [COORD_BITS-1:0] hi,
  input  logic signed [COORD_BITS-1:0] root_lo,
  input  logic signed [COORD_BITS-1:0] root_hi,
  input  logic                         inner,
  output logic signed [COORD_BITS-1:0] clamp,
  output logic signed [COORD_BITS-1:0] bound,
  output logic        [COORD_BITS-1:0] adiff,
  output logic        [COORD_BITS-1:0] fd,
  output pbsd_pkg::axis_flags_t        flags
);
  import pbsd_pkg::*;

  localparam int C = COORD_BITS;

  logic            below;
  logic            above;
  logic signed [C:0] dc;
  logic        [C:0] dmag;
  logic        [C:0] fd_lo;
  logic        [C:0] fd_hi;
  logic            lo_ok;
  logic            hi_ok;
  logic            take_hi;

  always_comb begin
    below = p < lo;
    above = p > hi;
    if (below) begin
      clamp = lo;
    end else if (above) begin
      clamp = hi;
    end else begin
      clamp = p;
    end
    dc    = {p[C-1], p} - {clamp[C-1], clamp};
    dmag  = dc[C] ? -dc : dc;
    adiff = dmag[C-1:0];

    // face distances are only meaningful when the point is inside
    fd_lo   = {p[C-1], p} - {lo[C-1], lo};
    fd_hi   = {hi[C-1], hi} - {p[C-1], p};
    lo_ok   = !(inner && (lo == root_lo));
    hi_ok   = !(inner && (hi == root_hi));
    take_hi = hi_ok && (!lo_ok || (fd_hi[C-1:0] < fd_lo[C-1:0]));
    fd      = take_hi ? fd_hi[C-1:0] : fd_lo[C-1:0];
    bound   = take_hi ? hi : lo;

    flags.outside = below || above;
    flags.face_ok = lo_ok || hi_ok;
  end
endmodule

FILE: sv/point_box_squared_distance.sv
// Point to axis-aligned box squared distance, one query per cycle unless the output stalls.
// Stages: input register, clamp/face pick per axis, axis pick, squares, sum.
// Throughput: one transfer per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles are absorbed.
// Reset (rst, synchronous): all stages empty, root box registers full range.
module point_box_squared_distance #(
  parameter int COORD_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  pbsd_query_if.sink                          query,
  pbsd_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pbsd_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [pbsd_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [pbsd_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import pbsd_pkg::*;

  localparam int C         = COORD_BITS;
  localparam int DIST_BITS = 2 * C + 2;

  localparam logic signed [C-1:0] MOST_NEG = {1'b1, {(C-1){1'b0}}};
  localparam logic signed [C-1:0] MOST_POS = {1'b0, {(C-1){1'b1}}};

  // root box registers
  logic signed [C-1:0]    root_lo [3];
  logic signed [C-1:0]    root_hi [3];
  logic                   wr_en;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[REG_IDX_BITS+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        root_lo[i] <= MOST_NEG;
        root_hi[i] <= MOST_POS;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROOT_MIN_X: root_lo[0] <= pwdata[C-1:0];
        REG_ROOT_MAX_X: root_hi[0] <= pwdata[C-1:0];
        REG_ROOT_MIN_Y: root_lo[1] <= pwdata[C-1:0];
        REG_ROOT_MAX_Y: root_hi[1] <= pwdata[C-1:0];
        REG_ROOT_MIN_Z: root_lo[2] <= pwdata[C-1:0];
        REG_ROOT_MAX_Z: root_hi[2] <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROOT_MIN_X: prdata = {{(APB_DATA_BITS-C){1'b0}}, root_lo[0]};
      REG_ROOT_MAX_X: prdata = {{(APB_DATA_BITS-C){1'b0}}, root_hi[0]};
      REG_ROOT_MIN_Y: prdata = {{(APB_DATA_BITS-C){1'b0}}, root_lo[1]};
      REG_ROOT_MAX_Y: prdata = {{(APB_DATA_BITS-C){1'b0}}, root_hi[1]};
      REG_ROOT_MIN_Z: prdata = {{(APB_DATA_BITS-C){1'b0}}, root_lo[2]};
      REG_ROOT_MAX_Z: prdata = {{(APB_DATA_BITS-C){1'b0}}, root_hi[2]};
      default:        prdata = '0;
    endcase
  end

  // pipeline flow control
  logic a_valid, b_valid, c_valid, d_valid, o_valid;
  logic en_a, en_b, en_c, en_d, en_o;

  assign en_o        = !o_valid || result.ready;
  assign en_d        = !d_valid || en_o;
  assign en_c        = !c_valid || en_d;
  assign en_b        = !b_valid || en_c;
  assign en_a        = !a_valid || en_b;
  assign query.ready = en_a;
  assign result.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (en_a) a_valid <= query.valid;
      if (en_b) b_valid <= a_valid;
      if (en_c) c_valid <= b_valid;
      if (en_d) d_valid <= c_valid;
      if (en_o) o_valid <= d_valid;
    end
  end

  // stage A: input register
  logic signed [C-1:0] a_p  [3];
  logic signed [C-1:0] a_lo [3];
  logic signed [C-1:0] a_hi [3];
  logic                a_inner;
  logic                a_empty;

  always_ff @(posedge clk) begin
    if (en_a && query.valid) begin
      a_p[0]  <= query.point_x;
      a_p[1]  <= query.point_y;
      a_p[2]  <= query.point_z;
      a_lo[0] <= query.box_min_x;
      a_lo[1] <= query.box_min_y;
      a_lo[2] <= query.box_min_z;
      a_hi[0] <= query.box_max_x;
      a_hi[1] <= query.box_max_y;
      a_hi[2] <= query.box_max_z;
      a_inner <= query.inner_only;
      a_empty <= query.check_data && query.node_empty;
    end
  end

  // stage B: per-axis clamp and face pick
  logic signed [C-1:0] ax_clamp [3];
  logic signed [C-1:0] ax_bound [3];
  logic        [C-1:0] ax_adiff [3];
  logic        [C-1:0] ax_fd    [3];
  axis_flags_t         ax_flags [3];

  for (genvar g = 0; g < 3; g++) begin : g_axis
    pbsd_axis #(.COORD_BITS(C)) u_axis (
      .p       (a_p[g]),
      .lo      (a_lo[g]),
      .hi      (a_hi[g]),
      .root_lo (root_lo[g]),
      .root_hi (root_hi[g]),
      .inner   (a_inner),
      .clamp   (ax_clamp[g]),
      .bound   (ax_bound[g]),
      .adiff   (ax_adiff[g]),
      .fd      (ax_fd[g]),
      .flags   (ax_flags[g])
    );
  end

  logic signed [C-1:0] b_p     [3];
  logic signed [C-1:0] b_clamp [3];
  logic signed [C-1:0] b_bound [3];
  logic        [C-1:0] b_adiff [3];
  logic        [C-1:0] b_fd    [3];
  axis_flags_t         b_flags [3];
  logic                b_empty;

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      for (int i = 0; i < 3; i++) begin
        b_p[i]     <= a_p[i];
        b_clamp[i] <= ax_clamp[i];
        b_bound[i] <= ax_bound[i];
        b_adiff[i] <= ax_adiff[i];
        b_fd[i]    <= ax_fd[i];
        b_flags[i] <= ax_flags[i];
      end
      b_empty <= a_empty;
    end
  end

  // stage C: axis pick, closest point, square operands
  logic                in_box;
  logic                have;
  logic        [1:0]   sel;
  logic        [C-1:0] best;
  logic signed [C-1:0] cl_next [3];
  logic        [C-1:0] op_next [3];
  logic                max_next;

  always_comb begin
    in_box = !(b_flags[0].outside || b_flags[1].outside || b_flags[2].outside);
    sel    = 2'd0;
    have   = b_flags[0].face_ok;
    best   = b_fd[0];
    if (b_flags[1].face_ok && (!have || (b_fd[1] < best))) begin
      sel  = 2'd1;
      have = 1'b1;
      best = b_fd[1];
    end
    if (b_flags[2].face_ok && (!have || (b_fd[2] < best))) begin
      sel  = 2'd2;
      have = 1'b1;
      best = b_fd[2];
    end

    for (int i = 0; i < 3; i++) begin
      cl_next[i] = b_p[i];
      op_next[i] = '0;
    end
    max_next = 1'b0;
    if (b_empty) begin
      max_next = 1'b1;
    end else if (!in_box) begin
      for (int i = 0; i < 3; i++) begin
        cl_next[i] = b_clamp[i];
        op_next[i] = b_adiff[i];
      end
    end else begin
      // with no face left, sel stays on x and b_bound[0] is box min x
      cl_next[sel] = b_bound[sel];
      op_next[0]   = best;
      max_next     = !have;
    end
  end

  logic signed [C-1:0] c_closest [3];
  logic        [C-1:0] c_op      [3];
  logic                c_max;

  always_ff @(posedge clk) begin
    if (en_c && b_valid) begin
      for (int i = 0; i < 3; i++) begin
        c_closest[i] <= cl_next[i];
        c_op[i]      <= op_next[i];
      end
      c_max <= max_next;
    end
  end

  // stage D: squares
  logic signed [C-1:0]   d_closest [3];
  logic        [2*C-1:0] d_sq      [3];
  logic                  d_max;

  always_ff @(posedge clk) begin
    if (en_d && c_valid) begin
      for (int i = 0; i < 3; i++) begin
        d_closest[i] <= c_closest[i];
        d_sq[i]      <= c_op[i] * c_op[i];
      end
      d_max <= c_max;
    end
  end

  // stage E: sum into the output register
  logic [DIST_BITS-1:0] dist_sum;

  assign dist_sum = DIST_BITS'(d_sq[0]) + DIST_BITS'(d_sq[1]) + DIST_BITS'(d_sq[2]);

  always_ff @(posedge clk) begin
    if (en_o && d_valid) begin
      result.dist_squared <= d_max ? {DIST_BITS{1'b1}} : dist_sum;
      result.dist_is_max  <= d_max;
      result.closest_x    <= d_closest[0];
      result.closest_y    <= d_closest[1];
      result.closest_z    <= d_closest[2];
    end
  end
endmodule

FILE: sv/pbsd_checker.sv
module pbsd_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2*COORD_BITS+1:0]      dist_squared,
  input logic                         dist_is_max,
  input logic signed [COORD_BITS-1:0] closest_x,
  input logic signed [COORD_BITS-1:0] closest_y,
  input logic signed [COORD_BITS-1:0] closest_z
);
  import pbsd_pkg::*;

  localparam int DIST_BITS = 2 * COORD_BITS + 2;

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when every stage is full and the output is stalled
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output can move");

  a_sentinel_ones: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dist_is_max) |-> (dist_squared == {DIST_BITS{1'b1}}))
    else $error("sentinel flag without all-ones distance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(dist_squared)
      && $stable(dist_is_max) && $stable(closest_x) && $stable(closest_y)
      && $stable(closest_z)))
    else $error("stalled result changed");
endmodule

bind point_box_squared_distance pbsd_checker #(.COORD_BITS(COORD_BITS)) u_pbsd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (query.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .dist_squared (result.dist_squared),
  .dist_is_max  (result.dist_is_max),
  .closest_x    (result.closest_x),
  .closest_y    (result.closest_y),
  .closest_z    (result.closest_z)
);

FILE: tb/sv/point_box_squared_distance_test.sv
`timescale 1ns / 1ps
module point_box_squared_distance_test;
  import pbsd_pkg::*;

  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 2 * COORD_BITS + 2;
  localparam int MOST_POS   = 8388607;
  localparam int MOST_NEG   = -8388608;
  localparam int UNIT       = 4096;

  // addresses past the root box registers, writes must be dropped
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic                         inner_only;
    logic                         check_data;
    logic                         node_empty;
  } query_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]         dist_squared;
    logic                         dist_is_max;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;
    logic signed [COORD_BITS-1:0] closest_z;
  } box_distance_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  pbsd_query_if  #(.COORD_BITS(COORD_BITS)) query ();
  pbsd_result_if #(.COORD_BITS(COORD_BITS)) result ();

  point_box_squared_distance #(.COORD_BITS(COORD_BITS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .query   (query),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  logic signed [COORD_BITS-1:0] root_lo [3];
  logic signed [COORD_BITS-1:0] root_hi [3];
  box_distance_t                pending_distances [$];

  int mismatches       = 0;
  int results_checked  = 0;
  int queries_accepted = 0;
  int random_queries   = 0;
  int sentinels        = 0;
  int reg_writes       = 0;
  int send_gap_max     = 10;
  int take_gap_max     = 10;
  int take_hold        = 0;

  function automatic box_distance_t predict_distance(query_t qi);
    longint        pt [3];
    longint        lo [3];
    longint        hi [3];
    longint        cl [3];
    longint        bound;
    longint        root_face;
    longint        gap;
    longint        best;
    longint        sum;
    bit            outside;
    bit            found;
    bit            upper;
    bit            is_max;
    int            ax;
    int            best_face;
    box_distance_t res;
    pt[0] = $signed(qi.point_x);
    pt[1] = $signed(qi.point_y);
    pt[2] = $signed(qi.point_z);
    lo[0] = $signed(qi.box_min_x);
    lo[1] = $signed(qi.box_min_y);
    lo[2] = $signed(qi.box_min_z);
    hi[0] = $signed(qi.box_max_x);
    hi[1] = $signed(qi.box_max_y);
    hi[2] = $signed(qi.box_max_z);
    sum = 0;
    best = 0;
    best_face = 0;
    outside = 1'b0;
    found = 1'b0;
    is_max = 1'b0;
    for (int a = 0; a < 3; a++) cl[a] = pt[a];
    if (qi.check_data && qi.node_empty) begin
      is_max = 1'b1;
    end else begin
      for (int a = 0; a < 3; a++) begin
        if (pt[a] < lo[a]) begin
          cl[a] = lo[a];
          outside = 1'b1;
        end else if (pt[a] > hi[a]) begin
          cl[a] = hi[a];
          outside = 1'b1;
        end
      end
      if (outside) begin
        for (int a = 0; a < 3; a++) sum += (pt[a] - cl[a]) * (pt[a] - cl[a]);
      end else begin
        // faces in order x-min, x-max, y-min, y-max, z-min, z-max; first wins ties
        for (int f = 0; f < 6; f++) begin
          ax = f / 2;
          upper = (f % 2) != 0;
          bound = upper ? hi[ax] : lo[ax];
          root_face = upper ? longint'(root_hi[ax]) : longint'(root_lo[ax]);
          gap = upper ? hi[ax] - pt[ax] : pt[ax] - lo[ax];
          if (qi.inner_only && bound == root_face) continue;
          if (!found || gap < best) begin
            found = 1'b1;
            best = gap;
            best_face = f;
          end
        end
        if (found) sum = best * best;
        else is_max = 1'b1;
        cl[best_face / 2] = (best_face % 2) ? hi[best_face / 2] : lo[best_face / 2];
      end
    end
    res.dist_squared = is_max ? '1 : sum[DIST_BITS-1:0];
    res.dist_is_max = is_max;
    res.closest_x = cl[0][COORD_BITS-1:0];
    res.closest_y = cl[1][COORD_BITS-1:0];
    res.closest_z = cl[2][COORD_BITS-1:0];
    return res;
  endfunction

  function automatic query_t make_query(int px, int py, int pz, int lx, int ly, int lz,
                                        int hx, int hy, int hz, bit inner, bit check,
                                        bit empty);
    query_t qi;
    qi.point_x = COORD_BITS'(px);
    qi.point_y = COORD_BITS'(py);
    qi.point_z = COORD_BITS'(pz);
    qi.box_min_x = COORD_BITS'(lx);
    qi.box_min_y = COORD_BITS'(ly);
    qi.box_min_z = COORD_BITS'(lz);
    qi.box_max_x = COORD_BITS'(hx);
    qi.box_max_y = COORD_BITS'(hy);
    qi.box_max_z = COORD_BITS'(hz);
    qi.inner_only = inner;
    qi.check_data = check;
    qi.node_empty = empty;
    return qi;
  endfunction

  function automatic longint any_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    return longint'(v);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > MOST_POS) return MOST_POS;
    if (v < MOST_NEG) return MOST_NEG;
    return v;
  endfunction

  // boxes of every size, some sharing faces with the root box, points on,
  // in, around and far from them
  function automatic query_t random_query();
    longint      lo [3];
    longint      hi [3];
    longint      pt [3];
    longint      span;
    int unsigned rnd;
    query_t      qi;
    for (int a = 0; a < 3; a++) begin
      rnd = $urandom & ((32'd1 << $urandom_range(0, 22)) - 1);
      span = longint'(rnd);
      case ($urandom_range(0, 9))
        0: begin
          lo[a] = any_coord();
          hi[a] = any_coord();
        end
        1: begin
          lo[a] = root_lo[a];
          hi[a] = root_hi[a];
        end
        2: begin
          lo[a] = root_lo[a];
          hi[a] = clamp_coord(lo[a] + span);
        end
        3: begin
          hi[a] = root_hi[a];
          lo[a] = clamp_coord(hi[a] - span);
        end
        default: begin
          lo[a] = any_coord();
          hi[a] = clamp_coord(lo[a] + span);
        end
      endcase
      rnd = $urandom;
      case ($urandom_range(0, 9))
        0: pt[a] = lo[a];
        1: pt[a] = hi[a];
        2: pt[a] = (lo[a] + hi[a]) / 2;
        3: pt[a] = clamp_coord(lo[a] - span - 1);
        4: pt[a] = clamp_coord(hi[a] + span + 1);
        5: pt[a] = any_coord();
        default: begin
          if (lo[a] <= hi[a]) pt[a] = lo[a] + longint'(rnd) % (hi[a] - lo[a] + 1);
          else pt[a] = any_coord();
        end
      endcase
    end
    qi.point_x = pt[0][COORD_BITS-1:0];
    qi.point_y = pt[1][COORD_BITS-1:0];
    qi.point_z = pt[2][COORD_BITS-1:0];
    qi.box_min_x = lo[0][COORD_BITS-1:0];
    qi.box_min_y = lo[1][COORD_BITS-1:0];
    qi.box_min_z = lo[2][COORD_BITS-1:0];
    qi.box_max_x = hi[0][COORD_BITS-1:0];
    qi.box_max_y = hi[1][COORD_BITS-1:0];
    qi.box_max_z = hi[2][COORD_BITS-1:0];
    qi.inner_only = 1'($urandom_range(0, 1));
    qi.check_data = ($urandom_range(0, 2) == 0);
    qi.node_empty = ($urandom_range(0, 3) == 0);
    return qi;
  endfunction

  // valid stays high into the next call when no gap is drawn
  task automatic send_query(input query_t qi);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query.valid <= 1'b1;
    query.point_x <= qi.point_x;
    query.point_y <= qi.point_y;
    query.point_z <= qi.point_z;
    query.box_min_x <= qi.box_min_x;
    query.box_min_y <= qi.box_min_y;
    query.box_min_z <= qi.box_min_z;
    query.box_max_x <= qi.box_max_x;
    query.box_max_y <= qi.box_max_y;
    query.box_max_z <= qi.box_max_z;
    query.inner_only <= qi.inner_only;
    query.check_data <= qi.check_data;
    query.node_empty <= qi.node_empty;
    do @(posedge clk); while (!query.ready);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_query(random_query());
    random_queries += count;
  endtask

  task automatic wait_for_results();
    query.valid <= 1'b0;
    do @(posedge clk); while (pending_distances.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_register(input logic [REG_IDX_BITS-1:0] idx,
                              input int value);
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'(value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(APB_DATA_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
    case (idx)
      REG_ROOT_MIN_X: root_lo[0] = v;
      REG_ROOT_MAX_X: root_hi[0] = v;
      REG_ROOT_MIN_Y: root_lo[1] = v;
      REG_ROOT_MAX_Y: root_hi[1] = v;
      REG_ROOT_MIN_Z: root_lo[2] = v;
      REG_ROOT_MAX_Z: root_hi[2] = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_root_box(input int lx, input int hx, input int ly, input int hy,
                              input int lz, input int hz);
    set_register(REG_ROOT_MIN_X, lx);
    set_register(REG_ROOT_MAX_X, hx);
    set_register(REG_ROOT_MIN_Y, ly);
    set_register(REG_ROOT_MAX_Y, hy);
    set_register(REG_ROOT_MIN_Z, lz);
    set_register(REG_ROOT_MAX_Z, hz);
  endtask

  task automatic test_faces_and_corners();
    int f;
    f = UNIT;
    send_query(make_query(0, 0, 0, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(3000, 0, 0, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(0, -3500, 0, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(0, 3600, 0, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(0, 0, -3700, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(0, 0, 3800, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS,
                          MOST_POS, MOST_POS, MOST_POS, 0, 0, 0));
    send_query(make_query(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_NEG, MOST_NEG, MOST_NEG, 1, 1, 0));
    send_query(make_query(10000, 10000, 0, -f, -f, -f, f, f, f, 0, 0, 0));
    send_query(make_query(f, 0, 0, -f, -f, -f, f, f, f, 0, 0, 0));
    // inverted x range: below min and above max at once, min wins
    send_query(make_query(0, 0, 0, 5000, -f, -f, -5000, f, f, 0, 0, 0));
    send_query(make_query(6000, 0, 0, 5000, -f, -f, -5000, f, f, 0, 0, 0));
    // empty data node beats inner-only
    send_query(make_query(123, -456, 789, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_POS, MOST_POS, MOST_POS, 1, 1, 1));
    send_query(make_query(9000, 0, 0, -f, -f, -f, f, f, f, 0, 1, 0));
    send_query(make_query(9000, 0, 0, -f, -f, -f, f, f, f, 0, 0, 1));
    send_query(make_query(5, 6, 7, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_POS, MOST_POS, MOST_POS, 1, 0, 0));
    send_query(make_query(-50000, 0, 0, MOST_NEG, MOST_NEG, MOST_NEG,
                          1000, MOST_POS, MOST_POS, 1, 0, 0));
    send_query(make_query(-1, -1, -1, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_POS, MOST_POS, MOST_POS, 0, 0, 0));
  endtask

  task automatic test_root_face_skipping();
    wait_for_results();
    set_root_box(-4 * UNIT, 4 * UNIT, -2 * UNIT, 2 * UNIT, -UNIT, UNIT);
    send_query(make_query(100, 200, 300, -4 * UNIT, -2 * UNIT, -UNIT,
                          4 * UNIT, 2 * UNIT, UNIT, 1, 0, 0));
    send_query(make_query(100, 200, 300, -4 * UNIT, -2 * UNIT, -UNIT,
                          4 * UNIT, 2 * UNIT, UNIT, 0, 0, 0));
    send_query(make_query(-16000, 0, 0, -4 * UNIT, -20000, -20000,
                          20000, 20000, 20000, 1, 0, 0));
    send_query(make_query(-16000, 0, 0, -4 * UNIT, -20000, -20000,
                          20000, 20000, 20000, 1, 1, 0));
    send_query(make_query(30000, 0, 0, -4 * UNIT, -2 * UNIT, -UNIT,
                          4 * UNIT, 2 * UNIT, UNIT, 1, 0, 0));
    wait_for_results();
    set_register(REG_SPARE_LO, 0);
    set_register(REG_SPARE_HI, 0);
    send_query(make_query(100, 200, 300, -4 * UNIT, -2 * UNIT, -UNIT,
                          4 * UNIT, 2 * UNIT, UNIT, 1, 0, 0));
    send_query(make_query(-16000, 0, 0, -4 * UNIT, -20000, -20000,
                          20000, 20000, 20000, 1, 0, 0));
  endtask

  task automatic test_output_backpressure();
    wait_for_results();
    send_gap_max = 0;
    take_gap_max = 0;
    take_hold = 80;
    send_random(40);
    wait_for_results();
    send_gap_max = 10;
    take_gap_max = 10;
  endtask

  task automatic test_sender_pause();
    send_random(30);
    wait_for_results();
    send_random(30);
  endtask

  task automatic test_random_queries();
    for (int ph = 0; ph < 8; ph++) begin
      wait_for_results();
      case (ph % 4)
        0: set_root_box(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
        1: set_root_box(-int'($urandom_range(0, 1 << 22)), $urandom_range(0, 1 << 22),
                        -int'($urandom_range(0, 1 << 22)), $urandom_range(0, 1 << 22),
                        -int'($urandom_range(0, 1 << 22)), $urandom_range(0, 1 << 22));
        2: set_root_box(0, 0, 0, 0, 0, 0);
        default: begin
          if (ph < 4) set_root_box(MOST_POS, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS, MOST_NEG);
          else set_root_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
      endcase
      send_gap_max = (ph % 3 == 2) ? 0 : 10;
      take_gap_max = (ph % 3 == 0) ? 10 : 0;
      send_random(100);
    end
    send_gap_max = 10;
    take_gap_max = 10;
  endtask

  always @(posedge clk) begin : query_capture
    query_t seen;
    if (!rst && query.valid && query.ready) begin
      seen.point_x = query.point_x;
      seen.point_y = query.point_y;
      seen.point_z = query.point_z;
      seen.box_min_x = query.box_min_x;
      seen.box_min_y = query.box_min_y;
      seen.box_min_z = query.box_min_z;
      seen.box_max_x = query.box_max_x;
      seen.box_max_y = query.box_max_y;
      seen.box_max_z = query.box_max_z;
      seen.inner_only = query.inner_only;
      seen.check_data = query.check_data;
      seen.node_empty = query.node_empty;
      pending_distances.push_back(predict_distance(seen));
      queries_accepted++;
    end
  end

  always @(posedge clk) begin : result_check
    box_distance_t got;
    box_distance_t want;
    if (!rst && result.valid && result.ready) begin
      got.dist_squared = result.dist_squared;
      got.dist_is_max = result.dist_is_max;
      got.closest_x = result.closest_x;
      got.closest_y = result.closest_y;
      got.closest_z = result.closest_z;
      if (pending_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: dist %h", got.dist_squared);
      end else begin
        want = pending_distances.pop_front();
        results_checked++;
        if (want.dist_is_max) sentinels++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected dist %h max %b closest (%0d, %0d, %0d)",
                     results_checked, want.dist_squared, want.dist_is_max,
                     $signed(want.closest_x), $signed(want.closest_y),
                     $signed(want.closest_z));
            $display("           got dist %h max %b closest (%0d, %0d, %0d)",
                     got.dist_squared, got.dist_is_max, $signed(got.closest_x),
                     $signed(got.closest_y), $signed(got.closest_z));
          end
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (take_hold > 0) begin
        result.ready <= 1'b0;
        repeat (take_hold) @(posedge clk);
        take_hold = 0;
      end else begin
        stall = $urandom_range(0, take_gap_max);
        if (stall > 0) begin
          result.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d results still outstanding", pending_distances.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    for (int a = 0; a < 3; a++) begin
      root_lo[a] = COORD_BITS'(MOST_NEG);
      root_hi[a] = COORD_BITS'(MOST_POS);
    end
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    query.valid <= 1'b0;
    query.point_x <= '0;
    query.point_y <= '0;
    query.point_z <= '0;
    query.box_min_x <= '0;
    query.box_min_y <= '0;
    query.box_min_z <= '0;
    query.box_max_x <= '0;
    query.box_max_y <= '0;
    query.box_max_z <= '0;
    query.inner_only <= 1'b0;
    query.check_data <= 1'b0;
    query.node_empty <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_faces_and_corners();
    test_root_face_skipping();
    test_output_backpressure();
    test_sender_pause();
    test_random_queries();

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("Checked %0d of %0d queries (%0d random) across %0d register writes",
             results_checked, queries_accepted, random_queries, reg_writes);
    $display("Sentinel distances seen: %0d; mismatching transfers: %0d",
             sentinels, mismatches);
    if (mismatches == 0 && pending_distances.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pbsd_pkg.sv
sv/pbsd_query_if.sv
sv/pbsd_result_if.sv
sv/pbsd_axis.sv
sv/point_box_squared_distance.sv
sv/pbsd_checker.sv
tb/sv/point_box_squared_distance_test.sv
